// ===== rtl/pltl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pltl_pkg: shared types and constants of the temperature linearizer
// Register indexes, request and range codes, and the front/back queue entry.
// ----------------------------------------------------------------------------
package pltl_pkg;

  localparam int MAX_POINTS_DEF = 32;

  localparam logic [5:0] IGBT_POINTS_RST  = 6'd20;
  localparam logic [5:0] MOTOR_POINTS_RST = 6'd14;
  localparam logic [7:0] IGBT_STEP_RST    = 8'd5;
  localparam logic [7:0] MOTOR_STEP_RST   = 8'd10;
  localparam logic [7:0] TEMP_ABOVE       = 8'hFF;
  localparam logic [7:0] TEMP_SAT         = 8'd254;

  localparam logic [1:0] REG_IGBT_POINTS  = 2'd0;
  localparam logic [1:0] REG_MOTOR_POINTS = 2'd1;
  localparam logic [1:0] REG_IGBT_STEP    = 2'd2;
  localparam logic [1:0] REG_MOTOR_STEP   = 2'd3;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  localparam logic [1:0] RANGE_OK    = 2'd0;
  localparam logic [1:0] RANGE_ABOVE = 2'd1;
  localparam logic [1:0] RANGE_BELOW = 2'd2;

  // job handed from front to back; data is the breakpoint value of a write
  // or the reading of a convert
  typedef struct packed {
    logic        req;
    logic        sel;
    logic [4:0]  idx;
    logic [15:0] data;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PAIR,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/piecewise_linear_temp_linearizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_temp_linearizer: table-based temperature linearizer
// A convert beat scans the table for the first breakpoint above the reading,
// one registered read per entry, then interpolates through a 24-step divider.
// A reading above the last point or below the first gives its range code
// without the divider. Beats are handled one at a time in order.
// Reset clears control and loads the config register defaults;
// table contents are undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_temp_linearizer
  import pltl_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] entry_index [20:5] entry_value [36:21] raw_reading [39:37] zero
  input  wire logic [39:0] s_axis_tdata,
  // [0] req_type [1] sensor_sel
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] temperature
  output logic [7:0]       m_axis_tdata,
  // [1:0] range_status
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [5:0] igbt_points, motor_points;
  logic [7:0] igbt_step, motor_step;

  logic        req;
  logic        sel;
  logic [4:0]  eidx;
  logic [15:0] evalue;
  logic [15:0] reading;
  assign req     = s_axis_tuser[0];
  assign sel     = s_axis_tuser[1];
  assign eidx    = s_axis_tdata[4:0];
  assign evalue  = s_axis_tdata[20:5];
  assign reading = s_axis_tdata[36:21];

  logic q_full, q_ne, q_pop;
  job_t q_head, q_in;
  logic accept;
  assign s_axis_tready = !q_full;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign q_in    = '{req: req, sel: sel, idx: eidx,
                     data: (req == REQ_WRITE) ? evalue : reading};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      igbt_points  <= IGBT_POINTS_RST;
      motor_points <= MOTOR_POINTS_RST;
      igbt_step    <= IGBT_STEP_RST;
      motor_step   <= MOTOR_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IGBT_POINTS:  igbt_points  <= cfg_data[5:0];
        REG_MOTOR_POINTS: motor_points <= cfg_data[5:0];
        REG_IGBT_STEP:    igbt_step    <= cfg_data;
        REG_MOTOR_STEP:   motor_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  pltl_queue u_queue (
    .clk, .rst,
    .push(accept), .push_job(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head(q_head)
  );

  logic [7:0] temp;
  logic [1:0] rng;
  pltl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst,
    .job_valid(q_ne), .job(q_head), .job_pop(q_pop),
    .igbt_points, .motor_points, .igbt_step, .motor_step,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_temp(temp), .out_range(rng)
  );

  assign m_axis_tdata = temp;
  assign m_axis_tuser = rng;

endmodule
`default_nettype wire

// ===== rtl/pltl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pltl_queue: two-entry job queue
// Decouples the accepting front end from the interpolation back end.
// ----------------------------------------------------------------------------
module pltl_queue
  import pltl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && not_empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(pop && not_empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> full) else $error("queue lost an entry");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/pltl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pltl_back: breakpoint search and interpolation
// Applies table writes in order, scans the table one registered read per entry,
// then multiplies and runs a serial divider.
// ----------------------------------------------------------------------------
module pltl_back
  import pltl_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_valid,
  input  wire job_t       job,
  output logic            job_pop,
  input  wire logic [5:0] igbt_points,
  input  wire logic [5:0] motor_points,
  input  wire logic [7:0] igbt_step,
  input  wire logic [7:0] motor_step,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_temp,
  output logic [1:0]      out_range
);

  localparam int AW = $clog2(2*MAX_POINTS);
  localparam int IW = $clog2(MAX_POINTS+1);

  logic [15:0] mem [2*MAX_POINTS];
  logic [15:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  back_state_t state, state_next;
  logic [IW-1:0] idx;
  logic [IW-1:0] npts;
  logic [7:0]  step;
  logic [15:0] reading;
  logic        sel;
  logic [15:0] lo;
  logic [15:0] span;
  logic [23:0] quo;
  logic [16:0] rem;
  logic [4:0]  dcnt;
  logic [15:0] basev;
  logic        rd_pend;
  logic [7:0]  res_temp;
  logic [1:0]  res_range;

  function automatic logic [IW-1:0] clamp_pts(input logic [5:0] n);
    if (n < 6'd2) return IW'(2);
    if (32'(n) > MAX_POINTS) return IW'(MAX_POINTS);
    return IW'(n);
  endfunction

  assign wr_en   = (state == ST_IDLE) && job_valid && (job.req == REQ_WRITE) &&
                   (32'(job.idx) < MAX_POINTS);
  assign wr_addr = (job.sel ? AW'(MAX_POINTS) : AW'(0)) + AW'(job.idx);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= job.data;
    rd_data <= mem[rd_addr];
  end

  logic [AW-1:0] sel_base;
  assign sel_base = sel ? AW'(MAX_POINTS) : AW'(0);
  assign rd_addr  = sel_base + AW'(idx);
  assign job_pop  = (state == ST_IDLE) && job_valid;

  logic [16:0] trial;
  logic [23:0] qfin;
  logic [23:0] tsum;
  assign trial = {rem[15:0], quo[23]} - {1'b0, span};
  assign qfin  = {quo[22:0], !trial[16]};
  assign tsum  = 24'(basev) + qfin;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (job_valid && (job.req == REQ_CONVERT)) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (rd_pend) begin
          if (reading < rd_data) begin
            state_next = (idx == IW'(0)) ? ST_OUT : ST_PAIR;
          end else if (idx + IW'(1) == npts) begin
            state_next = ST_OUT;
          end
        end
      end
      ST_PAIR:   if (rd_pend) state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (dcnt == 5'd23) state_next = ST_OUT;
      ST_OUT:    if (!out_valid) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          if (job_valid && (job.req == REQ_CONVERT)) begin
            sel     <= job.sel;
            reading <= job.data;
            npts    <= clamp_pts(job.sel ? motor_points : igbt_points);
            step    <= job.sel ? motor_step : igbt_step;
            idx     <= '0;
          end
        end
        ST_SEARCH: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else if (reading < rd_data) begin
            rd_pend <= 1'b0;
            span    <= rd_data;
            if (idx == IW'(0)) begin
              res_temp  <= 8'd0;
              res_range <= RANGE_BELOW;
            end else begin
              idx <= idx - IW'(1);
            end
          end else if (idx + IW'(1) == npts) begin
            res_temp  <= TEMP_ABOVE;
            res_range <= RANGE_ABOVE;
          end else begin
            // advance to the next entry and wait for its registered read
            idx     <= idx + IW'(1);
            rd_pend <= 1'b0;
          end
        end
        ST_PAIR: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            lo   <= rd_data;
            span <= span - rd_data;
          end
        end
        ST_MUL: begin
          basev <= 16'(idx) * 16'(step);
          quo   <= 24'(reading - lo) * 24'(step);
          rem   <= '0;
          dcnt  <= '0;
        end
        ST_DIV: begin
          dcnt <= dcnt + 5'd1;
          if (!trial[16]) begin
            rem <= trial;
            quo <= {quo[22:0], 1'b1};
          end else begin
            rem <= {rem[15:0], quo[23]};
            quo <= {quo[22:0], 1'b0};
          end
          if (dcnt == 5'd23) begin
            // saturate the sum at 254
            res_range <= RANGE_OK;
            if (tsum > 24'(TEMP_SAT))
              res_temp <= TEMP_SAT;
            else
              res_temp <= tsum[7:0];
          end
        end
        ST_OUT: begin
          // hold the previous beat until it is taken
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_temp  <= res_temp;
            out_range <= res_range;
          end
        end
        default: ;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> state == ST_IDLE) else $error("pop outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> idx < npts) else $error("search ran off table");

endmodule
`default_nettype wire
